### src/tds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_pkg
// Shared sizes, item codes and payload types of the task delay scheduler.
// ----------------------------------------------------------------------------
package tds_pkg;

  localparam int MAX_SLOTS = 8;

  // Field widths fixed by the item format.
  localparam int KIND_W  = 2;
  localparam int TASK_W  = 3;
  localparam int TICKS_W = 32;
  localparam int MASK_W  = 8;
  localparam int CFG_W   = 4;

  // Widths that follow from the number of slots.
  localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int CNT1_W   = CNT_W + 1;
  localparam int CMP_W    = (CNT_W > TASK_W) ? CNT_W : TASK_W;
  localparam int CFG_CMP_W = (CNT1_W > CFG_W) ? CNT1_W : CFG_W;

  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELAY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TASK_W-1:0]  task_index;
    logic [TICKS_W-1:0] wait_ticks;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  ready_mask;
    logic [TICKS_W-1:0] tick_count;
    logic               granted;
    logic [TASK_W-1:0]  granted_task;
  } out_item_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } grant_t;

endpackage
`default_nettype wire

### src/task_delay_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_delay_scheduler
// Per-task delay counters with tick countdown and round-robin dispatch.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_valid/in_ready/in_data; each one yields exactly one
// result on out_valid/out_ready/out_data. cfg_we/cfg_wdata set the number of
// live tasks; write it only while the block is idle. Slots at or above the
// new count are made ready again.
// The block works on one item at a time. A delay, dispatch or unused item
// goes to the done state, which loads the output register and raises
// out_valid. A tick walks the delay counter memory one slot per cycle, read
// and write-back overlapped, and goes to the done state once the last
// write-back is done, or with no live task without reading any slot. in_ready
// returns in the cycle the result is loaded, so a new item is taken only
// after the result of the last one is in the output register.
// The result sits in an output register: while the receiver stalls the
// block finishes its current item and then holds in_ready low until the
// register frees up.
// Reset (rst, synchronous) marks every task ready, zeroes the tick count and
// scan position, and sets the live count to zero. The counter memory needs no
// clearing; a counter is only used while its task is delayed.
// ----------------------------------------------------------------------------
module task_delay_scheduler (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire tds_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tds_pkg::out_item_t             out_data,
  input  wire logic                      cfg_we,
  input  wire logic [tds_pkg::CFG_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

  state_t                         state;
  logic [tds_pkg::MAX_SLOTS-1:0]  delayed;
  logic [tds_pkg::CNT_W-1:0]      live_n;
  logic [tds_pkg::SLOT_W-1:0]     scan_pos;
  logic [tds_pkg::TICKS_W-1:0]    tick_counter;
  logic                           granted;
  logic [tds_pkg::TASK_W-1:0]     granted_task;
  logic [tds_pkg::CNT_W-1:0]      rd_idx;
  logic                           pend;
  logic [tds_pkg::SLOT_W-1:0]     pend_idx;

  logic                           in_fire;
  logic                           delay_ok;
  logic                           dec_hit;
  logic                           mem_we;
  logic [tds_pkg::SLOT_W-1:0]     mem_waddr;
  logic [tds_pkg::TICKS_W-1:0]    mem_wdata;
  logic [tds_pkg::TICKS_W-1:0]    mem_rdata;
  logic [tds_pkg::TICKS_W-1:0]    dec_value;
  logic [tds_pkg::MAX_SLOTS-1:0]  live_mask;
  logic [tds_pkg::CNT_W-1:0]      cfg_live;
  logic [tds_pkg::SLOT_W-1:0]     scan_next;
  tds_pkg::grant_t                grant;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign delay_ok = (tds_pkg::CMP_W'(in_data.task_index) < tds_pkg::CMP_W'(live_n));

  // Slot under write-back during a tick walk.
  assign dec_value = mem_rdata - tds_pkg::TICKS_W'(1);
  assign dec_hit   = (state == ST_TICK) && pend && delayed[pend_idx] && (mem_rdata != '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_idx;
    mem_wdata = dec_value;
    if (dec_hit) begin
      mem_we = 1'b1;
    end else if (in_fire && (in_data.kind == tds_pkg::KIND_DELAY) && delay_ok) begin
      mem_we    = 1'b1;
      mem_waddr = in_data.task_index[tds_pkg::SLOT_W-1:0];
      mem_wdata = in_data.wait_ticks;
    end
  end

  always_comb begin
    for (int i = 0; i < tds_pkg::MAX_SLOTS; i++) begin
      live_mask[i] = (tds_pkg::CNT_W'(i) < live_n);
    end
  end

  assign cfg_live = (tds_pkg::CFG_CMP_W'(cfg_wdata) > tds_pkg::CFG_CMP_W'(tds_pkg::MAX_SLOTS)) ?
                    tds_pkg::CNT_W'(tds_pkg::MAX_SLOTS) : tds_pkg::CNT_W'(cfg_wdata);

  assign scan_next = (tds_pkg::CNT_W'(grant.idx) + tds_pkg::CNT_W'(1) == live_n) ?
                     '0 : tds_pkg::SLOT_W'(tds_pkg::CNT_W'(grant.idx) + tds_pkg::CNT_W'(1));

  tds_delay_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[tds_pkg::SLOT_W-1:0]),
    .rdata (mem_rdata)
  );

  tds_dispatch u_dispatch (
    .delayed  (delayed),
    .live_n   (live_n),
    .scan_pos (scan_pos),
    .grant    (grant)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      delayed      <= '0;
      live_n       <= '0;
      scan_pos     <= '0;
      tick_counter <= '0;
      granted      <= 1'b0;
      granted_task <= '0;
      rd_idx       <= '0;
      pend         <= 1'b0;
      pend_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        live_n <= cfg_live;
        for (int i = 0; i < tds_pkg::MAX_SLOTS; i++) begin
          if (tds_pkg::CNT_W'(i) >= cfg_live) begin
            delayed[i] <= 1'b0;
          end
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            granted      <= (in_data.kind == tds_pkg::KIND_DISPATCH) && grant.hit;
            granted_task <= ((in_data.kind == tds_pkg::KIND_DISPATCH) && grant.hit) ?
                            tds_pkg::TASK_W'(grant.idx) : '0;
            rd_idx       <= '0;
            pend         <= 1'b0;
            state        <= (in_data.kind == tds_pkg::KIND_TICK) ? ST_TICK : ST_DONE;
            case (in_data.kind)
              tds_pkg::KIND_TICK: begin
                tick_counter <= tick_counter + tds_pkg::TICKS_W'(1);
              end
              tds_pkg::KIND_DELAY: begin
                if (delay_ok) begin
                  delayed[in_data.task_index[tds_pkg::SLOT_W-1:0]] <= 1'b1;
                end
              end
              tds_pkg::KIND_DISPATCH: begin
                if (grant.hit) begin
                  scan_pos <= scan_next;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_TICK: begin
          // Read of slot rd_idx overlaps the write-back of slot pend_idx.
          if (rd_idx < live_n) begin
            rd_idx   <= rd_idx + tds_pkg::CNT_W'(1);
            pend     <= 1'b1;
            pend_idx <= rd_idx[tds_pkg::SLOT_W-1:0];
          end else begin
            pend <= 1'b0;
          end
          if (dec_hit && (dec_value == '0)) begin
            delayed[pend_idx] <= 1'b0;
          end
          if ((rd_idx == live_n) && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.ready_mask   <= tds_pkg::MASK_W'(~delayed & live_mask);
            out_data.tick_count   <= tick_counter;
            out_data.granted      <= granted;
            out_data.granted_task <= granted_task;
            out_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new transfer always takes the block out of the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("in_ready stayed high after a transfer");

  // Counter writes never touch a slot outside the live range.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (tds_pkg::CNT_W'(mem_waddr) < live_n))
    else $error("delay counter written outside the live slots");

  // The tick walk never runs past the live count.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TICK) |-> (rd_idx <= live_n))
    else $error("tick walk index beyond live count");

  // A granted task is reported ready in the same result.
  a_grant_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.granted) |-> out_data.ready_mask[out_data.granted_task])
    else $error("granted task not shown ready");

  // A slot cleared by a live count write is not delayed afterwards.
  a_dead_slots_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((delayed & ~live_mask) == '0))
    else $error("slot outside the live range is still delayed");

endmodule
`default_nettype wire

### src/tds_delay_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_delay_ram
// Per-slot delay counters: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tds_delay_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [tds_pkg::SLOT_W-1:0] waddr,
  input  wire logic [tds_pkg::TICKS_W-1:0] wdata,
  input  wire logic [tds_pkg::SLOT_W-1:0] raddr,
  output logic      [tds_pkg::TICKS_W-1:0] rdata
);

  logic [tds_pkg::TICKS_W-1:0] mem [tds_pkg::MAX_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/tds_dispatch.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tds_dispatch
// Round-robin picker: first ready live slot at or after the scan position.
// ----------------------------------------------------------------------------
module tds_dispatch (
  input  wire logic [tds_pkg::MAX_SLOTS-1:0] delayed,
  input  wire logic [tds_pkg::CNT_W-1:0]     live_n,
  input  wire logic [tds_pkg::SLOT_W-1:0]    scan_pos,
  output tds_pkg::grant_t                    grant
);

  logic [tds_pkg::CNT_W-1:0]  start;
  logic [tds_pkg::CNT1_W-1:0] cand;

  always_comb begin
    start = (tds_pkg::CNT_W'(scan_pos) < live_n) ? tds_pkg::CNT_W'(scan_pos) : '0;
    grant = '0;
    cand  = '0;
    // Walk downward so that the smallest offset from the start wins.
    for (int i = tds_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (tds_pkg::CNT_W'(i) < live_n) begin
        cand = tds_pkg::CNT1_W'(start) + tds_pkg::CNT1_W'(i);
        if (cand >= tds_pkg::CNT1_W'(live_n)) begin
          cand = cand - tds_pkg::CNT1_W'(live_n);
        end
        if (!delayed[cand[tds_pkg::SLOT_W-1:0]]) begin
          grant.hit = 1'b1;
          grant.idx = cand[tds_pkg::SLOT_W-1:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task delay scheduler testbench
// Runs a short scripted sequence covering the empty task set, an over-range
// task count, zero and maximum delays, dispatch with nothing ready and a scan
// position left out of range by a count change. It then runs about a thousand
// random items over several task counts. Each result is checked field by field
// against a scripted value or a behavioral model in step with each transfer.
// ----------------------------------------------------------------------------
module testbench;
  import tds_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = MAX_SLOTS + 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_COUNT     = 12;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg_val;
    in_item_t          item;
    bit                known;
    out_item_t         want;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Scheduler state as the testbench sees it.
  logic [TICKS_W-1:0] wait_left [MAX_SLOTS];
  bit                 is_delayed [MAX_SLOTS];
  logic [TICKS_W-1:0] ticks_seen;
  int unsigned        next_scan;
  int unsigned        task_limit;

  out_item_t   expected_status [$];
  script_row_t script [$];
  int          fails = 0;
  int          rx_idle_pct = 0;
  bit          hold_off_req = 1'b0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  task_delay_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned live_tasks();
    return (task_limit > MAX_SLOTS) ? MAX_SLOTS : task_limit;
  endfunction

  // Slots that fall outside the new count come back ready with a zero counter.
  function automatic void apply_task_limit(input logic [CFG_W-1:0] value);
    task_limit = 32'(value);
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i >= live_tasks()) begin
        wait_left[i]  = '0;
        is_delayed[i] = 1'b0;
      end
    end
  endfunction

  function automatic out_item_t schedule_step(input in_item_t it);
    int unsigned live;
    int unsigned start;
    int unsigned idx;
    out_item_t   rep;
    live = live_tasks();
    rep  = '0;
    case (it.kind)
      KIND_TICK: begin
        ticks_seen = ticks_seen + 1;
        for (int i = 0; i < live; i++) begin
          if (is_delayed[i] && wait_left[i] != 0) begin
            wait_left[i] = wait_left[i] - 1;
            if (wait_left[i] == 0) is_delayed[i] = 1'b0;
          end
        end
      end
      KIND_DELAY: begin
        if (it.task_index < live) begin
          wait_left[it.task_index]  = it.wait_ticks;
          is_delayed[it.task_index] = 1'b1;
        end
      end
      KIND_DISPATCH: begin
        if (live != 0) begin
          start = (next_scan < live) ? next_scan : 0;
          for (int i = 0; i < live; i++) begin
            idx = (start + i) % live;
            if (!rep.granted && !is_delayed[idx]) begin
              rep.granted      = 1'b1;
              rep.granted_task = idx[TASK_W-1:0];
              next_scan        = (idx + 1) % live;
            end
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < live; i++) rep.ready_mask[i] = !is_delayed[i];
    rep.tick_count = ticks_seen;
    return rep;
  endfunction

  function automatic void add_row(input bit known, input logic [KIND_W-1:0] kind,
                                  input logic [TASK_W-1:0] slot,
                                  input logic [TICKS_W-1:0] ticks,
                                  input out_item_t want = '0);
    script_row_t r;
    r.is_cfg           = 1'b0;
    r.cfg_val          = '0;
    r.item.kind        = kind;
    r.item.task_index  = slot;
    r.item.wait_ticks  = ticks;
    r.known            = known;
    r.want             = want;
    script.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [CFG_W-1:0] value);
    script_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_val = value;
    r.item    = '0;
    r.known   = 1'b0;
    r.want    = '0;
    script.push_back(r);
  endfunction

  function automatic in_item_t random_item(input int unsigned live);
    in_item_t    it;
    int unsigned pick;
    it.task_index = TASK_W'($urandom_range(0, 7));
    it.wait_ticks = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.kind = KIND_TICK;
    end else if (pick < 65) begin
      it.kind = KIND_DELAY;
      if (live != 0 && $urandom_range(0, 9) != 0)
        it.task_index = TASK_W'($urandom_range(0, live - 1));
      // Mostly short waits so that ticks release tasks often.
      pick = $urandom_range(0, 99);
      if (pick < 10) it.wait_ticks = '0;
      else if (pick < 80) it.wait_ticks = $urandom_range(1, 6);
      else if (pick < 92) it.wait_ticks = $urandom_range(7, 40);
    end else if (pick < 95) begin
      it.kind = KIND_DISPATCH;
    end else begin
      it.kind = KIND_SPARE;
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input in_item_t it, input bit known, input out_item_t want);
    out_item_t rep;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rep = schedule_step(it);
    expected_status.push_back(known ? want : rep);
    @(negedge clk);
  endtask

  task automatic maybe_pause_sender(input int pct);
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_task_limit(input logic [CFG_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_task_limit(value);
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    fails++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_data);
        fails++;
      end else begin
        want = expected_status.pop_front();
        if (out_data.ready_mask !== want.ready_mask)
          report_field("ready_mask", want.ready_mask, out_data.ready_mask);
        if (out_data.tick_count !== want.tick_count)
          report_field("tick_count", want.tick_count, out_data.tick_count);
        if (out_data.granted !== want.granted)
          report_field("granted", want.granted, out_data.granted);
        if (out_data.granted_task !== want.granted_task)
          report_field("granted_task", want.granted_task, out_data.granted_task);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_limits [PHASE_COUNT];
    in_item_t    it;
    int unsigned live;
    int          useful;
    int          phase_len;
    int          tx_idle_pct;
    bit          paused;

    phase_limits =
      '{4'd8, 4'd1, 4'd15, 4'd2, 4'd0, 4'd5, 4'd9, 4'd3, 4'd7, 4'd12, 4'd6, 4'd8};
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      wait_left[i]  = '0;
      is_delayed[i] = 1'b0;
    end
    ticks_seen = '0;
    next_scan  = 0;
    task_limit = 0;

    // With no live task nothing changes but the tick count.
    add_row(1, KIND_TICK, 0, 0, {8'h00, 32'd1, 1'b0, 3'd0});
    add_row(1, KIND_DISPATCH, 0, 0, {8'h00, 32'd1, 1'b0, 3'd0});
    add_row(1, KIND_DELAY, 0, 5, {8'h00, 32'd1, 1'b0, 3'd0});
    add_row(1, KIND_SPARE, 7, 32'hFFFF_FFFF, {8'h00, 32'd1, 1'b0, 3'd0});
    // A count above the slot total acts as a full set of slots.
    add_cfg(4'd15);
    add_row(1, KIND_SPARE, 7, 32'hFFFF_FFFF, {8'hFF, 32'd1, 1'b0, 3'd0});
    add_row(1, KIND_DISPATCH, 0, 0, {8'hFF, 32'd1, 1'b1, 3'd0});
    add_row(1, KIND_DELAY, 7, 0, {8'h7F, 32'd1, 1'b0, 3'd0});
    add_row(1, KIND_DELAY, 3, 32'hFFFF_FFFF, {8'h77, 32'd1, 1'b0, 3'd0});
    add_row(0, KIND_DELAY, 1, 1);
    add_row(0, KIND_TICK, 0, 0);
    add_row(0, KIND_DELAY, 2, 2);
    add_row(0, KIND_TICK, 7, 32'hFFFF_FFFF);
    add_row(0, KIND_TICK, 0, 0);
    add_row(0, KIND_DISPATCH, 7, 32'hFFFF_FFFF);
    add_row(0, KIND_DISPATCH, 0, 0);
    add_row(0, KIND_SPARE, 0, 0);
    // Shrinking the count leaves the scan position past the live range.
    add_cfg(4'd3);
    add_row(0, KIND_DISPATCH, 0, 0);
    add_row(0, KIND_DELAY, 5, 4);
    add_row(0, KIND_DELAY, 0, 0);
    add_row(0, KIND_DELAY, 1, 0);
    add_row(0, KIND_DELAY, 2, 3);
    add_row(0, KIND_DISPATCH, 0, 0);
    add_row(0, KIND_TICK, 0, 0);
    add_row(0, KIND_TICK, 0, 0);
    add_row(0, KIND_TICK, 0, 0);
    add_row(0, KIND_DISPATCH, 0, 0);
    add_cfg(4'd8);
    add_row(0, KIND_DISPATCH, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rx_idle_pct = 20;
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        write_task_limit(script[i].cfg_val);
      end else begin
        maybe_pause_sender(20);
        offer(script[i].item, script[i].known, script[i].want);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_task_limit(phase_limits[p]);
      live = live_tasks();
      phase_len = (live == 0) ? 20 : 90;
      if (p == PHASE_COUNT - 1) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(0, 2) * 15;
        rx_idle_pct = $urandom_range(0, 2) * 15;
      end
      // The receiver holds off while items keep coming, so the block backs up.
      if (p == 1) hold_off_req = 1'b1;
      paused = 1'b0;
      useful = 0;
      while (useful < phase_len) begin
        if (p == 5 && !paused && useful == phase_len / 2) begin
          drain();
          paused = 1'b1;
        end
        maybe_pause_sender((p == 1 && useful < 30) ? 0 : tx_idle_pct);
        it = random_item(live);
        offer(it, 1'b0, '0);
        if (it.kind != KIND_SPARE && !(it.kind == KIND_DELAY && it.task_index >= live))
          useful++;
      end
    end

    drain();
    if (fails == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
src/tds_pkg.sv
src/tds_delay_ram.sv
src/tds_dispatch.sv
src/task_delay_scheduler.sv
tb/testbench.sv
